// ===== design/crq_pkg.sv =====
package crq_pkg;

   // Fixed field widths of the command and response beats
   localparam int unsigned ACTION_BITS = 3;
   localparam int unsigned INDEX_BITS  = 4;
   localparam int unsigned DATA_BITS   = 64;
   localparam int unsigned COUNT_BITS  = 5;

   typedef logic [ACTION_BITS-1:0] action_type;
   typedef logic [INDEX_BITS-1:0]  index_type;
   typedef logic [DATA_BITS-1:0]   data_type;
   typedef logic [COUNT_BITS-1:0]  count_type;

   // Command codes
   localparam action_type ACT_PUSH      = 3'd0;
   localparam action_type ACT_POP       = 3'd1;
   localparam action_type ACT_OVERWRITE = 3'd2;
   localparam action_type ACT_TRUNCATE  = 3'd3;
   localparam action_type ACT_CLEAR     = 3'd4;

   // Per-cell control: shift toward the head, or load the write word
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ===== design/crq_channels.sv =====
interface crq_req_if;
   logic                  valid;
   logic                  ready;
   crq_pkg::action_type   action;
   crq_pkg::data_type     entry_data;
   crq_pkg::index_type    entry_index;

   modport source (output valid, output action, output entry_data, output entry_index,
                   input ready);
   modport sink   (input valid, input action, input entry_data, input entry_index,
                   output ready);
endinterface

interface crq_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  error;
   crq_pkg::count_type    count;
   crq_pkg::data_type     read_data;

   modport source (output valid, output error, output count, output read_data,
                   input ready);
   modport sink   (input valid, input error, input count, input read_data,
                   output ready);
endinterface

// ===== design/command_ring_queue.sv =====
// command_ring_queue: queue of controller-state words driven by push/pop/
//   overwrite/truncate/clear commands, one response beat per command beat.
// Response: registered; the response beat is valid in the cycle after its command beat is taken.
// Throughput: 1 command per cycle while the receiver takes each response; all cells update in the same cycle.
// Reset (synchronous, active high): count and pop phase clear, pop_removes = 1.
//   Stored words are not cleared; no clearing pass, commands taken right away.
module command_ring_queue #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned ENTRY_BITS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic          csr_wdata,
   crq_req_if.sink       req_chan,
   crq_rsp_if.source     rsp_chan
);

   // Count holds 0..DEPTH, position 0..DEPTH-1
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned PW   = $clog2(DEPTH);
   localparam int unsigned CMPW = (CW > crq_pkg::INDEX_BITS) ? CW : crq_pkg::INDEX_BITS;
   localparam int unsigned XW   = CW + crq_pkg::COUNT_BITS;

   // The row is kept compact: cell 0 holds the oldest word, cell count-1 the
   // newest. A removing pop shifts every cell one place toward cell 0.
   logic [CW-1:0]  count_ff, count_in;
   logic           phase_ff, phase_in;
   logic           removes_ff;

   logic           rsp_valid_ff;
   logic           rsp_error_ff, rsp_error_in;
   crq_pkg::count_type rsp_count_ff;
   crq_pkg::data_type  rsp_data_ff, rsp_data_in;

   logic           accept;
   logic           do_shift;
   logic           write_en;
   logic [PW-1:0]  write_pos;
   logic [CMPW-1:0] idx_x, count_x;
   logic           idx_ok;
   logic [XW-1:0]  count_wide;

   logic [ENTRY_BITS-1:0]  wdata;
   logic [ENTRY_BITS-1:0]  links [DEPTH+1];
   crq_pkg::cell_ctl_type  ctl [DEPTH];

   assign accept = req_chan.valid && req_chan.ready;
   // Output register frees as the waiting beat is taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign wdata   = req_chan.entry_data[ENTRY_BITS-1:0];
   assign idx_x   = CMPW'(req_chan.entry_index);
   assign count_x = CMPW'(count_ff);
   assign idx_ok  = idx_x < count_x;

   // Command decode
   always_comb begin
      count_in     = count_ff;
      phase_in     = phase_ff;
      do_shift     = 1'b0;
      write_en     = 1'b0;
      write_pos    = count_ff[PW-1:0];
      rsp_error_in = 1'b0;
      rsp_data_in  = '0;
      unique case (req_chan.action)
         crq_pkg::ACT_PUSH: begin
            if (count_ff == CW'(DEPTH)) begin
               rsp_error_in = 1'b1;
            end else begin
               write_en = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         crq_pkg::ACT_POP: begin
            if (count_ff == '0) begin
               rsp_error_in = 1'b1;
            end else begin
               rsp_data_in = crq_pkg::data_type'(links[0]);
               if (removes_ff) begin
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                  end else begin
                     // second pop of this word: it leaves
                     phase_in = 1'b0;
                     do_shift = 1'b1;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
         end
         crq_pkg::ACT_OVERWRITE: begin
            if (!idx_ok) begin
               rsp_error_in = 1'b1;
            end else begin
               write_en  = 1'b1;
               write_pos = PW'(count_x - idx_x - 1'b1);
            end
         end
         crq_pkg::ACT_TRUNCATE: begin
            if (!idx_ok) begin
               rsp_error_in = 1'b1;
            end else begin
               count_in = CW'(idx_x + 1'b1);
            end
         end
         crq_pkg::ACT_CLEAR: begin
            count_in = '0;
            phase_in = 1'b0;
         end
         default: begin
            rsp_error_in = 1'b1;
         end
      endcase
   end

   // Row of cells; the last one takes in zeros on a shift
   assign links[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctl[i].shift = accept && do_shift;
      assign ctl[i].load  = accept && write_en && (write_pos == PW'(i));

      crq_cell #(
         .ENTRY_BITS (ENTRY_BITS)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl[i]),
         .wdata    (wdata),
         .from_up  (links[i+1]),
         .data_out (links[i])
      );
   end

   assign count_wide = XW'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         removes_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            removes_ff <= csr_wdata;
         end
         if (accept) begin
            count_ff     <= count_in;
            phase_ff     <= phase_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_error_ff <= rsp_error_in;
         rsp_count_ff <= count_wide[crq_pkg::COUNT_BITS-1:0];
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.error     = rsp_error_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.read_data = rsp_data_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("held count above depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted command produced no response beat");

   a_phase_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> count_ff != '0)
      else $error("pop phase set on an empty queue");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.action == crq_pkg::ACT_PUSH && count_ff == CW'(DEPTH)
      |=> rsp_error_ff && $stable(count_ff))
      else $error("push into full queue not flagged");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_count_ff == crq_pkg::count_type'(count_ff))
      else $error("reported count differs from held count");
`endif

endmodule

// ===== design/crq_cell.sv =====
module crq_cell #(
   parameter int unsigned ENTRY_BITS = 64
) (
   input  logic                     clock,
   input  crq_pkg::cell_ctl_type    ctl,
   input  logic [ENTRY_BITS-1:0]    wdata,
   input  logic [ENTRY_BITS-1:0]    from_up,
   output logic [ENTRY_BITS-1:0]    data_out
);

   logic [ENTRY_BITS-1:0] data_ff;
   logic [ENTRY_BITS-1:0] data_in;

   always_comb begin
      if (ctl.load) begin
         data_in = wdata;
      end else if (ctl.shift) begin
         data_in = from_up;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== bench/tb.sv =====
module tb;

   localparam int unsigned RING_DEPTH   = 16;
   localparam int unsigned CLOCK_PERIOD = 8;
   localparam int unsigned RESET_CYCLES = 8;
   // Receiver hold-off length for the back-pressure stretch
   localparam int unsigned LONG_HOLD    = 60;
   // Watchdog: far above the slowest legal run (~600 beats, 62% gaps, long hold)
   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int unsigned ITEMS_PER_PHASE = 100;
   localparam int unsigned RANDOM_PHASES   = 6;

   // Action codes the block does not recognize; it must flag them and change nothing
   localparam crq_pkg::action_type ACT_RESERVED_LO = 3'd5;
   localparam crq_pkg::action_type ACT_RESERVED_HI = 3'd7;

   typedef struct packed {
      crq_pkg::action_type action;
      crq_pkg::data_type   entry_data;
      crq_pkg::index_type  entry_index;
   } command_beat_type;

   typedef struct packed {
      logic               error;
      crq_pkg::count_type count;
      crq_pkg::data_type  read_data;
   } response_beat_type;

   // ------------------------------------------------------------------
   // Queue model plus FIFO of predicted response beats
   // ------------------------------------------------------------------
   class queue_scoreboard;
      crq_pkg::data_type  ring[RING_DEPTH];
      int unsigned        head;
      int unsigned        tail;
      int unsigned        held;
      bit                 second_pop;
      bit                 removes;
      response_beat_type  predicted[$];
      int unsigned        fail_count;
      int unsigned        checked;
      int unsigned        error_beats;
      int unsigned        data_pops;

      function new();
         foreach (ring[i]) ring[i] = '0;
         head       = 0;
         tail       = 0;
         held       = 0;
         second_pop = 1'b0;
         removes    = 1'b1;
         fail_count = 0;
         checked    = 0;
         error_beats = 0;
         data_pops  = 0;
      endfunction

      function void set_removes(bit value);
         removes = value;
      endfunction

      // Apply one accepted command to the model and queue its response
      function void note_command(command_beat_type cmd);
         response_beat_type rsp;
         int unsigned       idx;
         idx           = cmd.entry_index;
         rsp.error     = 1'b0;
         rsp.read_data = '0;
         case (cmd.action)
            crq_pkg::ACT_PUSH: begin
               if (held >= RING_DEPTH) begin
                  rsp.error = 1'b1;
               end else begin
                  ring[tail] = cmd.entry_data;
                  tail       = (tail + 1) % RING_DEPTH;
                  held++;
               end
            end
            crq_pkg::ACT_POP: begin
               if (held == 0) begin
                  rsp.error = 1'b1;
               end else begin
                  rsp.read_data = ring[head];
                  // with removal on, the head leaves on every second pop
                  if (removes) begin
                     if (!second_pop) begin
                        second_pop = 1'b1;
                     end else begin
                        second_pop = 1'b0;
                        head       = (head + 1) % RING_DEPTH;
                        held--;
                     end
                  end
               end
            end
            crq_pkg::ACT_OVERWRITE: begin
               if (idx >= held) begin
                  rsp.error = 1'b1;
               end else begin
                  ring[(tail + RING_DEPTH - 1 - idx) % RING_DEPTH] = cmd.entry_data;
               end
            end
            crq_pkg::ACT_TRUNCATE: begin
               if (idx >= held) begin
                  rsp.error = 1'b1;
               end else begin
                  tail = (head + idx + 1) % RING_DEPTH;
                  held = idx + 1;
               end
            end
            crq_pkg::ACT_CLEAR: begin
               head       = 0;
               tail       = 0;
               held       = 0;
               second_pop = 1'b0;
            end
            default: begin
               rsp.error = 1'b1;
            end
         endcase
         rsp.count = crq_pkg::count_type'(held);
         predicted.push_back(rsp);
      endfunction

      task report(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         fail_count++;
      endtask

      task check_response(response_beat_type got);
         response_beat_type want;
         if (predicted.size() == 0) begin
            report($sformatf("unexpected response err=%0b count=%0d data=%h",
                             got.error, got.count, got.read_data));
            return;
         end
         want = predicted.pop_front();
         checked++;
         if (want.error) error_beats++;
         if (!want.error && want.read_data != '0) data_pops++;
         if (got.error !== want.error)
            report($sformatf("beat %0d error got %b want %b", checked, got.error, want.error));
         if (got.count !== want.count)
            report($sformatf("beat %0d count got %0d want %0d", checked, got.count, want.count));
         if (got.read_data !== want.read_data)
            report($sformatf("beat %0d read_data got %h want %h",
                             checked, got.read_data, want.read_data));
      endtask
   endclass

   // ------------------------------------------------------------------
   // DUT and channels
   // ------------------------------------------------------------------
   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   crq_req_if req_chan();
   crq_rsp_if rsp_chan();

   command_ring_queue #(
      .DEPTH      (RING_DEPTH),
      .ENTRY_BITS (crq_pkg::DATA_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   queue_scoreboard sb = new();

   // Gap percentages for sender and receiver, changed per pair of phases
   int unsigned tx_idle_pct;
   int unsigned rx_idle_pct;
   // Bumped by the stimulus to ask the receiver for one long hold-off
   int unsigned hold_requests;
   int unsigned sent_count;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("TIMEOUT: %0d of %0d responses seen", sb.checked, sent_count);
      $display("RESULT: ERROR");
      $finish;
   end

   // Monitor: all sampling at the rising edge sees pre-edge values, so a beat
   // here is exactly what the DUT took. Commands are noted before responses
   // in case both land on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_command('{req_chan.action, req_chan.entry_data, req_chan.entry_index});
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response('{rsp_chan.error, rsp_chan.count, rsp_chan.read_data});
      end
   end

   // Receiver: random ready, plus a long counted hold-off when asked for one.
   initial begin
      int unsigned hold_left;
      int unsigned holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_chan.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offer one command beat; returns on the edge where it was taken.
   // valid stays high on return so back-to-back beats never drop it.
   task automatic send_command(crq_pkg::action_type action, crq_pkg::data_type data,
                               crq_pkg::index_type idx);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.action      <= action;
      req_chan.entry_data  <= data;
      req_chan.entry_index <= idx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   // Drop valid, then let every response drain
   task automatic drain_queue();
      req_chan.valid <= 1'b0;
      while (sb.checked != sent_count) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Register write only while idle; the model follows on the same edge
   task automatic write_pop_removes(bit value);
      drain_queue();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_removes(value);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int unsigned          phase;
      int unsigned          n;
      int unsigned          roll;
      int unsigned          push_pct;
      crq_pkg::action_type  act;
      crq_pkg::data_type    data;
      crq_pkg::index_type   idx;

      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_wdata            <= 1'b0;
      req_chan.valid       <= 1'b0;
      req_chan.action      <= crq_pkg::ACT_PUSH;
      req_chan.entry_data  <= '0;
      req_chan.entry_index <= '0;
      tx_idle_pct   = 18;
      rx_idle_pct   = 62;
      hold_requests = 0;
      sent_count    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- Directed: removal on (reset value) ---
      // pop, overwrite and truncate on an empty queue all fail
      send_command(crq_pkg::ACT_POP, '0, '0);
      send_command(crq_pkg::ACT_OVERWRITE, '1, '0);
      send_command(crq_pkg::ACT_TRUNCATE, '0, '0);
      // fill to the brim with data extremes, alternating patterns and random words
      for (n = 0; n < RING_DEPTH; n++) begin
         case (n)
            0:       data = '1;
            1:       data = '0;
            2:       data = {crq_pkg::DATA_BITS/2{2'b10}};
            3:       data = {crq_pkg::DATA_BITS/2{2'b01}};
            default: data = {$urandom, $urandom};
         endcase
         send_command(crq_pkg::ACT_PUSH, data, crq_pkg::index_type'(n));
      end
      send_command(crq_pkg::ACT_PUSH, {$urandom, $urandom}, '1);      // full -> error
      send_command(crq_pkg::ACT_OVERWRITE, {$urandom, $urandom}, '1); // oldest, via newest-offset
      send_command(crq_pkg::ACT_OVERWRITE, '1, '0);                   // newest
      send_command(crq_pkg::ACT_POP, '0, '0);       // first pop: peek, phase set
      send_command(crq_pkg::ACT_POP, '0, '0);       // second pop removes head
      send_command(crq_pkg::ACT_TRUNCATE, '0, '1);  // index == count -> error
      send_command(crq_pkg::ACT_TRUNCATE, '0, '0);  // keep oldest only
      send_command(ACT_RESERVED_HI, '1, '1);        // unknown action
      send_command(ACT_RESERVED_LO, '0, '0);
      send_command(crq_pkg::ACT_CLEAR, '0, '0);

      // --- Random phases ---
      // Pop removal alternates each phase; gap profile: sender 18/receiver 62,
      // then 62/18, then none. Fill bias alternates so the queue both sits
      // at full and runs empty.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_pop_removes(phase[0]);
         case (phase / 2)
            0:       begin tx_idle_pct = 18; rx_idle_pct = 62; end
            1:       begin tx_idle_pct = 62; rx_idle_pct = 18; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         push_pct = phase[0] ? 30 : 50;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // back-pressure: receiver stalls long while the sender keeps offering
            if (phase == 4 && n == 20) hold_requests <= hold_requests + 1;
            roll = $urandom_range(99);
            if (roll < push_pct)  act = crq_pkg::ACT_PUSH;
            else if (roll < 80)   act = crq_pkg::ACT_POP;
            else if (roll < 90)   act = crq_pkg::ACT_OVERWRITE;
            else if (roll < 96)   act = crq_pkg::ACT_TRUNCATE;
            else if (roll < 98)   act = crq_pkg::ACT_CLEAR;
            else                  act = crq_pkg::action_type'(
                                           $urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI));
            case ($urandom_range(7))
               0:       data = '0;
               1:       data = '1;
               default: data = {$urandom, $urandom};
            endcase
            // mostly legal offsets so overwrite/truncate actually act
            if (sb.held > 0 && $urandom_range(3) != 0)
               idx = crq_pkg::index_type'($urandom_range(sb.held - 1));
            else
               idx = crq_pkg::index_type'($urandom_range(RING_DEPTH - 1));
            send_command(act, data, idx);
         end
      end

      // --- Wrap up ---
      drain_queue();
      repeat (4) @(posedge clock);
      if (sb.predicted.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.predicted.size()));
      $display("Ran %0d commands over both pop modes and three gap profiles with one long stall;",
               sent_count);
      $display("%0d responses checked, %0d flagged errors, %0d pops returned nonzero data.",
               sb.checked, sb.error_beats, sb.data_pops);
      if (sb.fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
